// ===== sv/saci_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sort ascending then increment: shared definitions
// Widths, capacity and the request, response and cell control word types.
// ----------------------------------------------------------------------------
package saci_pkg;

   // Batch capacity and element width.
   localparam int MAX_ITEMS   = 64;
   localparam int VALUE_WIDTH = 32;

   // The fill count must be able to hold MAX_ITEMS itself.
   localparam int COUNT_WIDTH = $clog2(MAX_ITEMS + 1);

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic signed [VALUE_WIDTH:0]   result_type;
   typedef logic [COUNT_WIDTH-1:0]        count_type;

   // One input word.
   typedef struct packed {
      value_type value;
      logic      last;
   } req_type;

   // One result word.
   typedef struct packed {
      result_type value_plus_one;
      logic       last_res;
      logic       dropped;
   } rsp_type;

   // Control broadcast to every cell of the chain.
   typedef struct packed {
      logic insert;   // place the new value, shifting larger ones right
      logic shift;    // move every value one cell toward the output
   } cell_ctrl_type;

endpackage

// ===== sv/saci_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sort cell
// One slot of the insertion chain. It holds one value, compares it with the
// broadcast new value and trades values with its two neighbors.
// ----------------------------------------------------------------------------
module saci_cell (
   input  logic                   clock,
   input  saci_pkg::cell_ctrl_type ctrl,
   input  logic                   occupied,
   input  saci_pkg::value_type    new_value,
   input  saci_pkg::value_type    left_value,
   input  logic                   left_gt,
   input  saci_pkg::value_type    right_value,
   output saci_pkg::value_type    value,
   output logic                   gt
);

   saci_pkg::value_type value_ff;
   saci_pkg::value_type value_in;
   logic                above;

   // An empty slot acts as larger than any value, so fills happen in order.
   assign above = !occupied || (value_ff > new_value);
   assign gt    = occupied && (value_ff > new_value);
   assign value = value_ff;

   // Shift takes right cell's value; insert, left's if it moves, else new.
   always_comb begin
      value_in = value_ff;
      if (ctrl.shift) begin
         value_in = right_value;
      end else if (ctrl.insert && above) begin
         value_in = left_gt ? left_value : new_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== sv/sort_ascending_then_increment.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sort ascending then increment: top level
// Insertion sorter over a chain of cells, draining sorted values plus one.
// ----------------------------------------------------------------------------
// Input words are taken one per cycle while a batch fills: each word is
// broadcast to a chain of MAX_ITEMS cells, and in that same cycle every cell
// holding a larger value passes it one place right while the new value drops
// into its slot, so equal values keep arrival order. The word with last set
// ends the batch; from the next cycle the chain shifts toward cell 0 and
// gives one result word per cycle that the consumer takes, smallest first.
// No input word is taken while a batch drains. Words that arrive with
// the chain full are discarded, and every result of that batch then has
// dropped set.
// ----------------------------------------------------------------------------
module sort_ascending_then_increment (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  saci_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output saci_pkg::rsp_type rsp_payload
);

   localparam saci_pkg::count_type FULL_COUNT =
      saci_pkg::COUNT_WIDTH'(saci_pkg::MAX_ITEMS);
   localparam saci_pkg::count_type ONE_COUNT = saci_pkg::COUNT_WIDTH'(1);

   logic                    drain_ff,    drain_in;
   logic                    overflow_ff, overflow_in;
   saci_pkg::count_type     count_ff,    count_in;

   logic                    req_fire;
   logic                    rsp_fire;
   logic                    full;
   logic                    final_rsp;
   saci_pkg::cell_ctrl_type ctrl;

   saci_pkg::value_type     cell_value [saci_pkg::MAX_ITEMS];
   logic                    cell_gt    [saci_pkg::MAX_ITEMS];
   logic                    cell_occ   [saci_pkg::MAX_ITEMS];

   // Handshakes.
   assign req_ready = !drain_ff;
   assign rsp_valid = drain_ff;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign full      = (count_ff == FULL_COUNT);
   assign final_rsp = (count_ff == ONE_COUNT);

   assign ctrl.insert = req_fire && !full;
   assign ctrl.shift  = rsp_fire;

   // The chain of cells.
   for (genvar i = 0; i < saci_pkg::MAX_ITEMS; i++) begin : g_cell
      saci_pkg::value_type left_value;
      saci_pkg::value_type right_value;
      logic                left_gt;

      assign cell_occ[i] = (saci_pkg::COUNT_WIDTH'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_value = req_payload.value;
         assign left_gt    = 1'b0;
      end else begin : g_body
         assign left_value = cell_value[i-1];
         assign left_gt    = cell_gt[i-1];
      end

      if (i == saci_pkg::MAX_ITEMS - 1) begin : g_tail
         assign right_value = cell_value[i];
      end else begin : g_inner
         assign right_value = cell_value[i+1];
      end

      saci_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (cell_occ[i]),
         .new_value   (req_payload.value),
         .left_value  (left_value),
         .left_gt     (left_gt),
         .right_value (right_value),
         .value       (cell_value[i]),
         .gt          (cell_gt[i])
      );
   end

   // Result word comes straight from the head cell.
   assign rsp_payload.value_plus_one =
      $signed({cell_value[0][saci_pkg::VALUE_WIDTH-1], cell_value[0]}) +
      (saci_pkg::VALUE_WIDTH + 1)'(1);
   assign rsp_payload.last_res = final_rsp;
   assign rsp_payload.dropped  = overflow_ff;

   // Fill count, overflow flag and drain phase.
   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      drain_in    = drain_ff;
      if (ctrl.insert) begin
         count_in = count_ff + ONE_COUNT;
      end else if (rsp_fire) begin
         count_in = count_ff - ONE_COUNT;
      end
      if (req_fire && full) begin
         overflow_in = 1'b1;
      end
      if (req_fire && req_payload.last) begin
         drain_in = 1'b1;
      end
      if (rsp_fire && final_rsp) begin
         drain_in    = 1'b0;
         overflow_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_ff    <= 1'b0;
         overflow_ff <= 1'b0;
         count_ff    <= '0;
      end else begin
         drain_ff    <= drain_in;
         overflow_ff <= overflow_in;
         count_ff    <= count_in;
      end
   end

   // The fill count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("fill count above capacity");

   // A drain phase always has at least one word to give.
   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      drain_ff |-> count_ff != '0)
      else $error("drain with empty chain");

   // The end of a batch starts the drain on the next cycle.
   a_last_starts_drain: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_payload.last) |=> rsp_valid)
      else $error("batch end did not start drain");

   // The final result leaves the chain empty and clears the overflow flag.
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && final_rsp) |=> (count_ff == '0 && !overflow_ff && !rsp_valid))
      else $error("state not cleared after final result");

   // Results within a batch come out in ascending order.
   a_ascending: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && !final_rsp) |=>
         (rsp_payload.value_plus_one >= $past(rsp_payload.value_plus_one)))
      else $error("results out of order");

endmodule

// ===== dv/sort_ascending_then_increment_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sort ascending then increment: testbench
// Feeds batches of signed words and checks each sorted, incremented result.
// ----------------------------------------------------------------------------
// A driver takes words from a backlog and offers them with random gaps. Each
// accepted word goes through a shadow insertion sorter that queues the
// results the batch should give. A monitor stalls at random and compares
// every result word, field by field, with the oldest queued result. Batches
// cover the value extremes, equal values, and a batch that fills the store
// to capacity and then overflows it, final word included.
// ----------------------------------------------------------------------------
module sort_ascending_then_increment_tb;

   localparam int CLOCK_HIGH_NS     = 4;
   localparam int CLOCK_LOW_NS      = 4;
   localparam int RANDOM_WORDS      = 16;
   localparam int QUIET_TAIL        = 25;
   localparam int LONG_HOLD         = 300;
   localparam int LONG_HOLD_START   = 20;
   localparam int SETTLE_CYCLES     = 2 * saci_pkg::MAX_ITEMS + 10;
   localparam int CYCLE_LIMIT       = 200000;
   localparam int REPORT_LIMIT      = 10;

   localparam saci_pkg::value_type VALUE_MIN =
      {1'b1, {(saci_pkg::VALUE_WIDTH-1){1'b0}}};
   localparam saci_pkg::value_type VALUE_MAX =
      {1'b0, {(saci_pkg::VALUE_WIDTH-1){1'b1}}};

   // A word waiting to be offered; some wait until every result is in.
   typedef struct {
      saci_pkg::req_type word;
      bit                hold_for_drain;
   } backlog_entry_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   saci_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   saci_pkg::rsp_type rsp_payload;

   backlog_entry_type req_backlog[$];
   saci_pkg::rsp_type sorted_plus_one_q[$];

   // Shadow copy of the sorter state.
   saci_pkg::value_type shadow_store[saci_pkg::MAX_ITEMS];
   int                  shadow_count   = 0;
   bit                  shadow_dropped = 1'b0;

   int send_gap       = 0;
   int recv_gap       = 0;
   int long_hold_left = 0;
   bit long_hold_done = 1'b0;
   int results_seen   = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   sort_ascending_then_increment u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #CLOCK_LOW_NS  clock = 1'b1;
      #CLOCK_HIGH_NS clock = 1'b0;
   end

   // Insert one accepted word into the shadow store; on the final word of a
   // batch, queue every stored value plus one, smallest first.
   function automatic void absorb_word(saci_pkg::req_type w);
      int                   pos;
      int                   i;
      saci_pkg::value_type  v;
      saci_pkg::result_type widened;
      saci_pkg::rsp_type    res;
      v = w.value;
      if (shadow_count >= saci_pkg::MAX_ITEMS) begin
         shadow_dropped = 1'b1;
      end else begin
         // Larger values move right; equal ones stay ahead of the new value.
         pos = shadow_count;
         while (pos > 0 && shadow_store[pos-1] > v) begin
            shadow_store[pos] = shadow_store[pos-1];
            pos--;
         end
         shadow_store[pos] = v;
         shadow_count++;
      end
      if (w.last) begin
         for (i = 0; i < shadow_count; i++) begin
            widened = shadow_store[i];
            res.value_plus_one = widened + 1;
            res.last_res       = (i == shadow_count - 1);
            res.dropped        = shadow_dropped;
            sorted_plus_one_q.push_back(res);
         end
         shadow_count   = 0;
         shadow_dropped = 1'b0;
      end
   endfunction

   // Values crowd around zero and the extremes often, so equal values and
   // the increment at both ends come up regularly.
   function automatic saci_pkg::value_type draw_value();
      case ($urandom_range(0, 3))
         0: draw_value = $urandom_range(0, 8) - 4;
         1: begin
            case ($urandom_range(0, 3))
               0: draw_value = VALUE_MIN;
               1: draw_value = VALUE_MAX;
               2: draw_value = VALUE_MIN + 1;
               default: draw_value = VALUE_MAX - 1;
            endcase
         end
         default: draw_value = $urandom;
      endcase
   endfunction

   function automatic void queue_word(saci_pkg::value_type v, bit last, bit hold);
      backlog_entry_type e;
      e.word.value     = v;
      e.word.last      = last;
      e.hold_for_drain = hold;
      req_backlog.push_back(e);
   endfunction

   function automatic void queue_batch(int length, bit hold);
      int k;
      for (k = 0; k < length; k++) begin
         queue_word(draw_value(), k == length - 1, hold && k == 0);
      end
   endfunction

   // Driver: offers backlog words, predicts on each accepted one.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            absorb_word(req_payload);
         end
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (req_backlog.size() == 0) begin
               req_valid <= 1'b0;
            end else if (req_backlog[0].hold_for_drain && sorted_plus_one_q.size() != 0) begin
               req_valid <= 1'b0;
            end else if (req_backlog.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0) begin
               send_gap  <= $urandom_range(0, 9);
               req_valid <= 1'b0;
            end else begin
               req_valid   <= 1'b1;
               req_payload <= req_backlog[0].word;
               void'(req_backlog.pop_front());
            end
         end
      end
   end

   // One long stall of the result side, while words keep being offered.
   always @(posedge clock) begin
      if (reset) begin
         long_hold_left <= 0;
         long_hold_done <= 1'b0;
      end else if (!long_hold_done && rsp_valid && results_seen >= LONG_HOLD_START) begin
         long_hold_left <= LONG_HOLD;
         long_hold_done <= 1'b1;
      end else if (long_hold_left != 0) begin
         long_hold_left <= long_hold_left - 1;
      end
   end

   // Monitor: checks every accepted result word and drives the stalls.
   always @(posedge clock) begin : monitor
      saci_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen <= results_seen + 1;
            if (sorted_plus_one_q.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT) begin
                  $display("Unexpected result word: value %0d last %0b dropped %0b",
                           rsp_payload.value_plus_one, rsp_payload.last_res,
                           rsp_payload.dropped);
               end
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = sorted_plus_one_q.pop_front();
               if (rsp_payload.value_plus_one !== want.value_plus_one ||
                   rsp_payload.last_res !== want.last_res ||
                   rsp_payload.dropped !== want.dropped) begin
                  if (mismatch_count < REPORT_LIMIT) begin
                     $display("Result mismatch: expected value %0d last %0b dropped %0b,",
                              want.value_plus_one, want.last_res, want.dropped);
                     $display("   got value %0d last %0b dropped %0b",
                              rsp_payload.value_plus_one, rsp_payload.last_res,
                              rsp_payload.dropped);
                  end
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (recv_gap != 0) begin
            recv_gap  <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else if (req_backlog.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0) begin
            recv_gap  <= $urandom_range(0, 9);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= (long_hold_left == 0);
         end
      end
   end

   // Timeout guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Stimulus and end of run.
   initial begin : stimulus
      int n;
      int random_words;

      // Single-word batches at both ends of the range and at minus one.
      queue_word(VALUE_MIN, 1'b1, 1'b0);
      queue_word(VALUE_MAX, 1'b1, 1'b0);
      queue_word(saci_pkg::value_type'(-1), 1'b1, 1'b0);
      // Mixed batch with repeated values and both extremes.
      queue_word(saci_pkg::value_type'(5), 1'b0, 1'b0);
      queue_word(saci_pkg::value_type'(-3), 1'b0, 1'b0);
      queue_word(saci_pkg::value_type'(5), 1'b0, 1'b0);
      queue_word(saci_pkg::value_type'(0), 1'b0, 1'b0);
      queue_word(saci_pkg::value_type'(-1), 1'b0, 1'b0);
      queue_word(VALUE_MIN, 1'b0, 1'b0);
      queue_word(VALUE_MAX, 1'b0, 1'b0);
      queue_word(saci_pkg::value_type'(-3), 1'b1, 1'b0);
      // Descending arrival, so every word lands at the front.
      queue_word(saci_pkg::value_type'(3), 1'b0, 1'b0);
      queue_word(saci_pkg::value_type'(2), 1'b0, 1'b0);
      queue_word(saci_pkg::value_type'(1), 1'b0, 1'b0);
      queue_word(saci_pkg::value_type'(0), 1'b1, 1'b0);
      // Already ascending pair.
      queue_word(saci_pkg::value_type'(-7), 1'b0, 1'b0);
      queue_word(saci_pkg::value_type'(7), 1'b1, 1'b0);

      // Random batches, mostly short; the first waits for a drained block.
      random_words = 0;
      while (random_words < RANDOM_WORDS) begin
         if ($urandom_range(0, 7) == 0) begin
            n = $urandom_range(9, 20);
         end else begin
            n = $urandom_range(1, 8);
         end
         queue_batch(n, random_words == 0);
         random_words += n;
      end

      // Store filled to capacity, then overflowed including the final word.
      // Its tail also forms the quiet end of the run.
      queue_batch(saci_pkg::MAX_ITEMS + $urandom_range(1, 3), 1'b0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (sorted_plus_one_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && sorted_plus_one_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/saci_pkg.sv
sv/saci_cell.sv
sv/sort_ascending_then_increment.sv
dv/sort_ascending_then_increment_tb.sv
